// ===== rtl/core/dp2p_pkg.sv =====
`timescale 1ns / 1ps
package dp2p_pkg;

   localparam int DIVIDEND_W  = 64;
   localparam int DIVISOR_W   = 32;
   localparam int RADICAND_W  = 64;
   localparam int ROOT_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_MIN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_MAX    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EYE_DISTANCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_SCALE      = 3'd5;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VX,
      ST_VX_WAIT,
      ST_VY,
      ST_VY_WAIT,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_D,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_CMUL,
      ST_CDIV,
      ST_CDIV_WAIT,
      ST_ZMUL,
      ST_ZRND,
      ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sh0_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -50'sh0_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/depth_pixel_to_point.sv =====
`timescale 1ns / 1ps
// Depth pixel to 3-D point projection.
// Pixels come in on the req_ channel column by column, top to bottom, one depth
// sample per transfer. A pixel strictly inside (depth_min, depth_max) gives one
// point on the rsp_ channel with its running index in the frame; others give none
// but still advance the column and row counters.
// Registers are written through csr_write_enable / csr_index / csr_data; the user
// must write them only while the block is idle, as the block does not enforce it.
// A rejected pixel does not stall the channel. A kept pixel holds req_stall high
// until its point is done; the point shows on rsp_valid in the same cycle as
// req_stall drops, and the next pixel can follow then. The work is two divisions
// for the virtual point, the squares of vx, vy and the eye distance, a square root,
// three multiply + divide steps, z scaling (ZMUL, ZRND) and an output step.
// The shared 32-step divider serves both virtual-point divisions and all three steps.
// The finished point sits in an output register; the next pixel is taken while
// it waits. If rsp_stall holds and another point is ready, the block waits.
// Synchronous reset restores register defaults and clears counters and rsp_valid.
module depth_pixel_to_point #(
   parameter int MAX_SIDE = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [dp2p_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dp2p_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [31:0]                    req_depth,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [31:0]                    rsp_point_x,
   output logic signed [31:0]                    rsp_point_y,
   output logic signed [31:0]                    rsp_point_z,
   output logic [19:0]                           rsp_point_index
);
   import dp2p_pkg::*;

   localparam int CW = $clog2(MAX_SIDE + 1);
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   // configuration
   logic signed [31:0] depth_min_ff, depth_max_ff, z_scale_ff;
   logic [30:0]        eye_distance_ff;
   logic [10:0]        frame_width_ff, frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_min_ff    <= 32'sd0;
         depth_max_ff    <= 32'sh7FFF_FFFF;
         eye_distance_ff <= 31'd65536;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
         z_scale_ff      <= 32'sd65536;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DEPTH_MIN:    depth_min_ff    <= csr_data;
            REG_DEPTH_MAX:    depth_max_ff    <= csr_data;
            REG_EYE_DISTANCE: eye_distance_ff <= csr_data[30:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[10:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[10:0];
            REG_Z_SCALE:      z_scale_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   logic [CW-1:0] w_c, h_c;
   logic [30:0]   d_c;

   always_comb begin
      if (frame_width_ff == 11'd0) begin
         w_c = CW'(1);
      end else if (int'(frame_width_ff) > MAX_SIDE) begin
         w_c = CW'(MAX_SIDE);
      end else begin
         w_c = CW'(frame_width_ff);
      end
      if (frame_height_ff == 11'd0) begin
         h_c = CW'(1);
      end else if (int'(frame_height_ff) > MAX_SIDE) begin
         h_c = CW'(MAX_SIDE);
      end else begin
         h_c = CW'(frame_height_ff);
      end
      d_c = (eye_distance_ff == 31'd0) ? 31'd1 : eye_distance_ff;
   end

   // position counters
   state_type     state_ff, state_in;
   logic [CW-1:0] col_ff, row_ff;
   logic [19:0]   pe_ff;
   logic [CW-1:0] u1, v1, u2, v2;
   logic [19:0]   pe1, pe2;
   logic          hit, req_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      hit = (req_depth > depth_min_ff) && (req_depth < depth_max_ff);
      u1  = col_ff;
      v1  = row_ff;
      pe1 = pe_ff;
      if (v1 >= h_c) begin
         v1 = '0;
         u1 = col_ff + 1'b1;
      end
      if (u1 >= w_c) begin
         u1  = '0;
         pe1 = '0;
      end
      pe2 = hit ? pe1 + 1'b1 : pe1;
      u2  = u1;
      v2  = v1 + 1'b1;
      if (v2 >= h_c) begin
         v2 = '0;
         u2 = u1 + 1'b1;
      end
      if (u2 >= w_c) begin
         u2  = '0;
         pe2 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         pe_ff  <= '0;
      end else if (req_xfer) begin
         col_ff <= u2;
         row_ff <= v2;
         pe_ff  <= pe2;
      end
   end

   // datapath
   logic [CW-1:0]        u_ff, v_ff;
   logic [19:0]          idx_ff;
   logic signed [31:0]   depth_ff;
   logic signed [27:0]   vx_ff, vy_ff;
   logic                 neg_ff;
   logic [63:0]          acc_ff;
   logic [31:0]          norm_ff;
   logic [1:0]           comp_ff;
   logic signed [65:0]   prod_ff;
   logic signed [31:0]   px_ff, py_ff, pz_ff;
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [19:0]          rsp_idx_ff;

   logic signed [32:0]   mul_a, mul_b;
   logic                 div_start, root_start;
   logic [63:0]          div_dividend;
   logic [31:0]          div_divisor, div_quotient, root_value;
   unit_status_type      div_status, root_status;

   logic signed [CW+1:0] vnum;
   logic [CW+1:0]        vmag;
   logic [CW-1:0]        vside;
   logic                 prod_neg;
   logic [65:0]          prod_mag;
   logic [63:0]          zsum;
   logic signed [27:0]   vq;
   logic signed [33:0]   cq;
   logic signed [34:0]   csum;
   logic signed [27:0]   cbase;
   logic signed [49:0]   zval;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      vside    = (state_ff == ST_VY) ? v_ff : u_ff;
      vnum     = $signed({1'b0, vside, 1'b0}) -
                 $signed({2'b00, (state_ff == ST_VY) ? h_c : w_c});
      vmag     = (vnum < 0) ? -vnum : vnum;
      prod_neg = prod_ff < 0;
      prod_mag = prod_neg ? -prod_ff : prod_ff;
      zsum     = prod_mag[63:0] + 64'd32768;
      zval     = prod_neg ? -$signed({2'b00, zsum[63:16]}) : $signed({2'b00, zsum[63:16]});
      vq       = neg_ff ? -$signed({1'b0, div_quotient[26:0]})
                        : $signed({1'b0, div_quotient[26:0]});
      cq       = neg_ff ? -$signed({2'b00, div_quotient}) : $signed({2'b00, div_quotient});
      case (comp_ff)
         COMP_X:  cbase = vx_ff;
         COMP_Y:  cbase = vy_ff;
         default: cbase = '0;
      endcase
      csum     = 35'(cq) + 35'(cbase);
   end

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      root_start   = 1'b0;
      div_dividend = (64'(vmag) << 16) + 64'(w_c);
      div_divisor  = 32'({w_c, 1'b0});
      mul_a        = 33'(vx_ff);
      mul_b        = 33'(vx_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && hit) begin
               state_in = ST_VX;
            end
         end
         ST_VX: begin
            div_start = 1'b1;
            state_in  = ST_VX_WAIT;
         end
         ST_VX_WAIT: begin
            if (div_status.done) begin
               state_in = ST_VY;
            end
         end
         ST_VY: begin
            div_start = 1'b1;
            state_in  = ST_VY_WAIT;
         end
         ST_VY_WAIT: begin
            if (div_status.done) begin
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            mul_a    = 33'(vy_ff);
            mul_b    = 33'(vy_ff);
            state_in = ST_SQ_D;
         end
         ST_SQ_D: begin
            mul_a    = $signed({2'b00, d_c});
            mul_b    = $signed({2'b00, d_c});
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            root_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (root_status.done) begin
               state_in = ST_CMUL;
            end
         end
         ST_CMUL: begin
            case (comp_ff)
               COMP_X:  mul_a = 33'(vx_ff);
               COMP_Y:  mul_a = 33'(vy_ff);
               default: mul_a = -$signed({2'b00, d_c});
            endcase
            mul_b    = 33'(depth_ff);
            state_in = ST_CDIV;
         end
         ST_CDIV: begin
            div_start    = 1'b1;
            div_dividend = prod_mag[63:0] + 64'(norm_ff >> 1);
            div_divisor  = norm_ff;
            state_in     = ST_CDIV_WAIT;
         end
         ST_CDIV_WAIT: begin
            if (div_status.done) begin
               state_in = (comp_ff == COMP_Z) ? ST_ZMUL : ST_CMUL;
            end
         end
         ST_ZMUL: begin
            mul_a    = 33'(pz_ff);
            mul_b    = 33'(z_scale_ff);
            state_in = ST_ZRND;
         end
         ST_ZRND: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (req_xfer) begin
         u_ff     <= u1;
         v_ff     <= v1;
         idx_ff   <= pe1;
         depth_ff <= req_depth;
         comp_ff  <= COMP_X;
      end
      case (state_ff)
         ST_VX, ST_VY: neg_ff <= vnum < 0;
         ST_VX_WAIT:   if (div_status.done) vx_ff <= vq;
         ST_VY_WAIT:   if (div_status.done) vy_ff <= vq;
         ST_SQ_Y:      acc_ff <= prod_ff[63:0];
         ST_SQ_D:      acc_ff <= acc_ff + prod_ff[63:0];
         ST_ROOT_WAIT: begin
            if (root_status.done) begin
               norm_ff <= (root_value == 32'd0) ? 32'd1 : root_value;
            end
         end
         ST_CDIV:      neg_ff <= prod_neg;
         ST_CDIV_WAIT: begin
            if (div_status.done) begin
               case (comp_ff)
                  COMP_X:  px_ff <= sat32(50'(csum));
                  COMP_Y:  py_ff <= sat32(50'(csum));
                  default: pz_ff <= sat32(50'(csum));
               endcase
               comp_ff <= comp_ff + 1'b1;
            end
         end
         ST_ZRND:      pz_ff <= sat32(zval);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_x_ff   <= px_ff;
         rsp_y_ff   <= py_ff;
         rsp_z_ff   <= pz_ff;
         rsp_idx_ff <= idx_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_point_z     = rsp_z_ff;
   assign rsp_point_index = rsp_idx_ff;

   dp2p_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   dp2p_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (acc_ff + prod_ff[63:0]),
      .root     (root_value),
      .status   (root_status)
   );

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_VX_WAIT || state_ff == ST_VY_WAIT ||
                           state_ff == ST_CDIV_WAIT))
      else $error("divider result with no one waiting");

   a_root_done_wait: assert property (@(posedge clock) disable iff (reset)
      root_status.done |-> state_ff == ST_ROOT_WAIT)
      else $error("root result with no one waiting");

   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CDIV |-> norm_ff != 32'd0)
      else $error("zero norm at division");

   a_reject_idle: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !hit) |=> state_ff == ST_IDLE)
      else $error("rejected pixel started a computation");

endmodule

// ===== rtl/core/dp2p_divider.sv =====
`timescale 1ns / 1ps
module dp2p_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dp2p_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [dp2p_pkg::DIVISOR_W-1:0]    divisor,
   output logic [dp2p_pkg::DIVISOR_W-1:0]    quotient,
   output dp2p_pkg::unit_status_type         status
);
   import dp2p_pkg::*;

   // quotient is known to fit DIVISOR_W bits, so the top half starts as remainder
   localparam int CNT_W = $clog2(DIVISOR_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[DIVISOR_W-1]};
      fits     = trial >= {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = dividend[DIVIDEND_W-1 -: DIVISOR_W];
         quo_in   = dividend[DIVISOR_W-1:0];
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? DIVISOR_W'(trial - {1'b0, div_ff}) : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVISOR_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DIVISOR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/core/dp2p_sqrt.sv =====
`timescale 1ns / 1ps
module dp2p_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dp2p_pkg::RADICAND_W-1:0]   radicand,
   output logic [dp2p_pkg::ROOT_W-1:0]       root,
   output dp2p_pkg::unit_status_type         status
);
   import dp2p_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADICAND_W-1:0] num_ff, num_in;
   logic [RADICAND_W-1:0] res_ff, res_in;
   logic [RADICAND_W-1:0] bit_ff, bit_in;
   logic [RADICAND_W-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         num_in  = radicand;
         res_in  = '0;
         bit_in  = RADICAND_W'(1) << (RADICAND_W - 2);
      end else if (busy_ff) begin
         if (num_ff >= trial) begin
            num_in = num_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == RADICAND_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root        = res_ff[ROOT_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== dv/tb_depth_pixel_to_point.sv =====
`timescale 1ns / 1ps
module tb_depth_pixel_to_point;
   import dp2p_pkg::*;

   localparam int LIMIT = 1_200_000;
   localparam int SETTLE = 250;
   localparam int PHASES = 23;
   localparam int PHASE_ITEMS = 62;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [19:0]        index;
   } point_type;

   typedef struct {
      logic [31:0] depth;
      bit          no_point;
   } pixel_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_depth = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic [19:0] rsp_point_index;

   depth_pixel_to_point DUT (.*);

   // shadow of the block
   logic signed [31:0] cfg_min, cfg_max, cfg_zscale;
   logic [30:0] cfg_eye;
   logic [10:0] cfg_width, cfg_height;
   int unsigned col_pos, row_pos;
   logic [19:0] point_count;

   point_type points_due[$];
   int fails = 0;
   int cycles = 0;
   bit calm = 0;
   int stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAIL depth_pixel_to_point");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fails++;
   endtask

   function automatic longint div_nearest(input longint n, input longint d);
      longint unsigned mag, q;
      mag = (n < 0) ? longint'(-n) : n;
      q = (mag + d / 2) / d;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic int unsigned side_of(input logic [10:0] s);
      if (s == 0) return 1;
      if (s > 1024) return 1024;
      return 32'(s);
   endfunction

   function automatic void advance_wrap(input int unsigned w, input int unsigned h);
      if (row_pos >= h) begin
         row_pos = 0;
         col_pos++;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         point_count = 0;
      end
   endfunction

   function automatic bit project_pixel(input logic signed [31:0] dep);
      int unsigned w, h;
      longint d, vx, vy, norm, px, py, pz;
      longint unsigned sum;
      point_type p;
      bit made;
      w = side_of(cfg_width);
      h = side_of(cfg_height);
      made = 0;
      advance_wrap(w, h);
      if (dep > cfg_min && dep < cfg_max) begin
         d = (cfg_eye == 0) ? 1 : longint'(cfg_eye);
         vx = div_nearest((2 * longint'(col_pos) - longint'(w)) * 65536, 2 * longint'(w));
         vy = div_nearest((2 * longint'(row_pos) - longint'(h)) * 65536, 2 * longint'(w));
         sum = longint'(vx * vx) + longint'(vy * vy) + d * d;
         norm = root_floor(sum);
         if (norm < 1) norm = 1;
         px = clip32(vx + div_nearest(vx * longint'(dep), norm));
         py = clip32(vy + div_nearest(vy * longint'(dep), norm));
         pz = clip32(div_nearest(-d * longint'(dep), norm));
         pz = clip32(div_nearest(pz * longint'(cfg_zscale), 65536));
         p.x = px[31:0];
         p.y = py[31:0];
         p.z = pz[31:0];
         p.index = point_count;
         points_due.push_back(p);
         point_count++;
         made = 1;
      end
      row_pos++;
      advance_wrap(w, h);
      return made;
   endfunction

   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (points_due.size() == 0) begin
            flag_mismatch("unexpected point, index", rsp_point_index, -1);
         end else begin
            e = points_due.pop_front();
            if (rsp_point_x !== e.x) flag_mismatch("point_x", rsp_point_x, e.x);
            if (rsp_point_y !== e.y) flag_mismatch("point_y", rsp_point_y, e.y);
            if (rsp_point_z !== e.z) flag_mismatch("point_z", rsp_point_z, e.z);
            if (rsp_point_index !== e.index)
               flag_mismatch("point_index", rsp_point_index, e.index);
         end
      end
   end

   always @(negedge clock) begin
      if (calm) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic push_pixel(input logic [31:0] dep, output bit made);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1;
      req_depth <= dep;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      made = project_pixel(dep);
      @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      case (idx)
         REG_DEPTH_MIN:    cfg_min = data;
         REG_DEPTH_MAX:    cfg_max = data;
         REG_EYE_DISTANCE: cfg_eye = data[30:0];
         REG_FRAME_WIDTH:  cfg_width = data[10:0];
         REG_FRAME_HEIGHT: cfg_height = data[10:0];
         REG_Z_SCALE:      cfg_zscale = data;
         default: ;
      endcase
   endtask

   task automatic drain;
      req_valid <= 0;
      wait (points_due.size() == 0);
      @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_side;
      logic [31:0] s;
      case ($urandom_range(0, 5))
         0: s = $urandom_range(1, 4);
         1, 2, 3: s = $urandom_range(1, 16);
         4: s = $urandom_range(17, 1024);
         default: s = $urandom_range(0, 2047);
      endcase
      return ($urandom & ~32'h7FF) | s;
   endfunction

   task automatic random_setup;
      int lo;
      lo = $urandom_range(0, 20 * 65536) - 10 * 65536;
      if ($urandom_range(0, 7) == 0) begin
         put_reg(REG_DEPTH_MIN, $urandom);
         put_reg(REG_DEPTH_MAX, $urandom);
      end else begin
         put_reg(REG_DEPTH_MIN, lo);
         put_reg(REG_DEPTH_MAX, lo + $urandom_range(2, 40 * 65536));
      end
      case ($urandom_range(0, 7))
         0: put_reg(REG_EYE_DISTANCE, $urandom);
         1: put_reg(REG_EYE_DISTANCE, {1'($urandom_range(0, 1)), 31'd0});
         default: put_reg(REG_EYE_DISTANCE, $urandom_range(1, 8 * 65536));
      endcase
      put_reg(REG_FRAME_WIDTH, pick_side());
      put_reg(REG_FRAME_HEIGHT, pick_side());
      if ($urandom_range(0, 5) == 0) put_reg(REG_Z_SCALE, $urandom);
      else put_reg(REG_Z_SCALE, $urandom_range(0, 4 * 65536) - 2 * 65536);
      if ($urandom_range(0, 3) == 0) put_reg(REG_SPARE_6, $urandom);
      if ($urandom_range(0, 3) == 0) put_reg(REG_SPARE_7, $urandom);
      csr_write_enable <= 0;
   endtask

   function automatic logic [31:0] pick_depth;
      longint span;
      span = longint'(cfg_max) - longint'(cfg_min);
      case ($urandom_range(0, 11))
         0: return $urandom;
         1: return {1'($urandom_range(0, 1)), {31{$urandom_range(0, 1) == 1}}};
         2: return cfg_min;
         3: return cfg_max;
         default: begin
            if (span < 2) return $urandom;
            return 32'(longint'(cfg_min) + 1 + ({$urandom, $urandom} % (span - 1)));
         end
      endcase
   endfunction

   pixel_row_type opening [16] = '{
      '{32'h0000_0000, 1}, '{32'h0000_0001, 0}, '{32'h7FFF_FFFF, 1},
      '{32'h7FFF_FFFE, 0}, '{32'h8000_0000, 1}, '{32'hFFFF_FFFF, 1},
      '{32'h0001_0000, 0}, '{32'hFFFF_0000, 1}, '{32'h00A0_0000, 0},
      '{32'h4000_0000, 0}, '{32'h5555_5555, 0}, '{32'h2AAA_AAAA, 0},
      '{32'h0000_8000, 0}, '{32'h7F00_0000, 0}, '{32'h8000_0001, 1},
      '{32'h0123_4567, 0}
   };

   initial begin
      bit made;
      cfg_min = 0;
      cfg_max = 32'h7FFF_FFFF;
      cfg_eye = 65536;
      cfg_width = 640;
      cfg_height = 480;
      cfg_zscale = 65536;
      col_pos = 0;
      row_pos = 0;
      point_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (opening[i]) begin
         push_pixel(opening[i].depth, made);
         if (made == opening[i].no_point)
            flag_mismatch("point made for directed pixel", made, !opening[i].no_point);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         calm = (p >= PHASES - 3) || ($urandom_range(0, 4) == 0);
         if (p == 0) begin
            put_reg(REG_DEPTH_MIN, 32'h8000_0000);
            put_reg(REG_DEPTH_MAX, 32'h7FFF_FFFF);
            put_reg(REG_EYE_DISTANCE, 32'h0);
            put_reg(REG_FRAME_WIDTH, 32'h0);
            put_reg(REG_FRAME_HEIGHT, 32'h0);
            put_reg(REG_Z_SCALE, 32'h8000_0000);
            csr_write_enable <= 0;
         end else if (p == 1) begin
            put_reg(REG_DEPTH_MIN, 32'hFFFF_0000);
            put_reg(REG_DEPTH_MAX, 32'h0001_0000);
            put_reg(REG_EYE_DISTANCE, 32'hFFFF_FFFF);
            put_reg(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
            put_reg(REG_FRAME_HEIGHT, 32'h0000_07FF);
            put_reg(REG_Z_SCALE, 32'h7FFF_FFFF);
            csr_write_enable <= 0;
         end else begin
            random_setup();
         end
         for (int k = 0; k < PHASE_ITEMS; k++) push_pixel(pick_depth(), made);
      end

      drain();
      if (fails == 0) begin
         $display("PASS depth_pixel_to_point");
      end else begin
         $display("FAIL depth_pixel_to_point");
      end
      $finish;
   end

endmodule
